FILE: src/ssri_pkg.sv
// shared types, constants and popcount helpers for the sparse slot rank index
`timescale 1ns / 1ps

package ssri_pkg;

	localparam int MAP_WORDS = 3;
	localparam int MAX_PROPS = 256;
	localparam int MAP_BITS  = MAP_WORDS * 32;
	localparam int MAP_IDX_W = $clog2(MAP_BITS);
	localparam int POP_W     = $clog2(MAP_BITS + 1);

	localparam logic REG_PROP_COUNT = 1'b0;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_MAP    = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_PRESENT   = 2'd0,
		ST_UNMAPPED  = 2'd1,
		ST_UNDEFINED = 2'd2,
		ST_INVALID   = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] prop_index;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] offset;
		logic [8:0] total_slots;
	} rsp_t;

	function automatic logic [5:0] pop32(input logic [31:0] v);
		logic [31:0] x;
		x = ((v & 32'hAAAAAAAA) >> 1) + (v & ~32'hAAAAAAAA);
		x = ((x & 32'hCCCCCCCC) >> 2) + (x & ~32'hCCCCCCCC);
		x = ((x & 32'hF0F0F0F0) >> 4) + (x & ~32'hF0F0F0F0);
		x = ((x & 32'hFF00FF00) >> 8) + (x & ~32'hFF00FF00);
		x = ((x & 32'hFFFF0000) >> 16) + (x & ~32'hFFFF0000);
		return x[5:0];
	endfunction

	function automatic logic [POP_W-1:0] pop_map(input logic [MAP_BITS-1:0] v);
		logic [POP_W-1:0] n;
		n = '0;
		for (int w = 0; w < MAP_WORDS; w++) begin
			n = n + POP_W'(pop32(v[w*32 +: 32]));
		end
		return n;
	endfunction

endpackage

FILE: src/ssri_cfg.sv
// apb register port holding the property count
`timescale 1ns / 1ps

module ssri_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [8:0]  prop_count
);
	import ssri_pkg::*;

	logic [8:0] prop_count_q;
	logic       wr_en;
	logic [8:0] wr_val;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_PROP_COUNT);
	// values above the class limit saturate
	assign wr_val = (pwdata[8:0] > 9'(MAX_PROPS)) ? 9'(MAX_PROPS) : pwdata[8:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_count_q <= '0;
		end else if (wr_en) begin
			prop_count_q <= wr_val;
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_PROP_COUNT) begin
			prdata = {23'd0, prop_count_q};
		end
	end

	assign prop_count = prop_count_q;

endmodule

FILE: src/ssri_core.sv
// presence bitmap with rank, map and clear logic for one registered item
`timescale 1ns / 1ps

module ssri_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_s1,
	input  ssri_pkg::req_t req_s1,
	input  logic [8:0]    prop_count,
	output ssri_pkg::rsp_t rsp
);
	import ssri_pkg::*;

	logic [MAP_BITS-1:0] bits_q;
	logic [MAP_BITS-1:0] below_mask;
	logic [7:0]          idx;
	logic                defined;
	logic                in_map;
	logic                bit_at;
	logic [POP_W-1:0]    pop_total;
	logic [POP_W-1:0]    rank;
	logic [8:0]          extra;
	logic [8:0]          beyond_off;
	logic [8:0]          pop_after;
	logic                do_set;
	logic                do_clear;

	assign idx     = req_s1.prop_index;
	assign defined = {1'b0, idx} < prop_count;
	assign in_map  = 32'(idx) < 32'(MAP_BITS);
	assign bit_at  = in_map && bits_q[idx[MAP_IDX_W-1:0]];

	always_comb begin
		for (int i = 0; i < MAP_BITS; i++) begin
			below_mask[i] = 32'(i) < 32'(idx);
		end
	end

	assign pop_total = pop_map(bits_q);
	// setting the bit itself leaves the count below it unchanged
	assign rank      = pop_map(bits_q & below_mask);

	assign extra = (prop_count > 9'(MAP_BITS)) ? (prop_count - 9'(MAP_BITS)) : 9'd0;
	// always-present slots past the bitmap; wraps to the offset width
	assign beyond_off = {1'b0, idx} + 9'(pop_total) - 9'(MAP_BITS);

	assign do_set   = vld_s1 && (req_s1.operation == OP_MAP) && defined && in_map && !bit_at;
	assign do_clear = vld_s1 && (req_s1.operation == OP_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
		end else if (do_clear) begin
			bits_q <= '0;
		end else if (do_set) begin
			bits_q[idx[MAP_IDX_W-1:0]] <= 1'b1;
		end
	end

	always_comb begin
		rsp.status = ST_PRESENT;
		rsp.offset = '0;
		pop_after  = 9'(pop_total);
		case (req_s1.operation)
			OP_LOOKUP: begin
				if (!defined) begin
					rsp.status = ST_UNDEFINED;
				end else if (!in_map) begin
					rsp.offset = beyond_off[7:0];
				end else if (!bit_at) begin
					rsp.status = ST_UNMAPPED;
				end else begin
					rsp.offset = 8'(rank);
				end
			end
			OP_MAP: begin
				if (!defined) begin
					rsp.status = ST_UNDEFINED;
				end else if (!in_map || bit_at) begin
					rsp.status = ST_INVALID;
				end else begin
					rsp.offset = 8'(rank);
					pop_after  = 9'(pop_total) + 9'd1;
				end
			end
			OP_CLEAR: begin
				pop_after = '0;
			end
			default: begin
				rsp.status = ST_INVALID;
			end
		endcase
		rsp.total_slots = pop_after + extra;
	end

endmodule

FILE: src/sparse_slot_rank_index.sv
// Sparse slot rank index: presence bitmap over the first 96 property indices.
//
// Commands enter on start with a request item (operation, prop_index); start is
// taken whenever busy is low, and busy is always low, so one item per cycle.
// Operations: lookup returns the packed slot offset, map sets the presence bit
// and returns the new offset, clear empties the bitmap. Every result carries
// the total slot count after the operation.
// The item is registered at the accepting edge, worked on by the 96-bit masked
// popcount, and the result is registered at the edge after: done rises at that
// edge and stays high for exactly one cycle, so the result is taken at the edge
// that ends the done pulse.
// Throughput 1 item per cycle; back-to-back items see the bitmap as left by the
// one before. The receiver cannot stall; each result is valid only while done
// is high. prop_count is written through the apb port at byte address 0; the
// user must do so only while idle, as the block does not enforce it. Reset
// clears the bitmap, prop_count and the pipeline valid flags.
`timescale 1ns / 1ps

module sparse_slot_rank_index (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ssri_pkg::req_t request,
	output logic          done,
	output ssri_pkg::rsp_t result,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import ssri_pkg::*;

	logic       vld_s1;
	req_t       req_s1;
	logic       vld_s2;
	rsp_t       rsp_s2;
	rsp_t       rsp;
	logic [8:0] prop_count;

	assign busy = 1'b0;

	ssri_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.prop_count (prop_count)
	);

	ssri_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.vld_s1     (vld_s1),
		.req_s1     (req_s1),
		.prop_count (prop_count),
		.rsp        (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= request;
		end
		if (vld_s1) begin
			rsp_s2 <= rsp;
		end
	end

	assign done   = vld_s2;
	assign result = rsp_s2;

endmodule
